### sv/fdt_node_extent_scanner_macros.svh
// Assertion macros used by the top-level RTL of the node extent scanner.
// Each macro expects clk and rst_n in scope.
`ifndef FDT_NODE_EXTENT_SCANNER_MACROS_SVH
`define FDT_NODE_EXTENT_SCANNER_MACROS_SVH

// Same-cycle implication.
`define FDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/fdt_nes_pkg.sv
// ----------------------------------------------------------------------------
// fdt_nes_pkg
// Types and codes shared by the node extent scanner modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fdt_nes_pkg;

    // structure-block tokens
    localparam logic [31:0] TOKEN_BEGIN_NODE = 32'd1;
    localparam logic [31:0] TOKEN_END_NODE   = 32'd2;
    localparam logic [31:0] TOKEN_PROP       = 32'd3;
    localparam logic [31:0] TOKEN_NOP        = 32'd4;

    // classified token codes
    localparam logic [2:0] TK_BEGIN    = 3'd0;
    localparam logic [2:0] TK_END_NODE = 3'd1;
    localparam logic [2:0] TK_PROP     = 3'd2;
    localparam logic [2:0] TK_NOP      = 3'd3;
    localparam logic [2:0] TK_BAD      = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BAD   = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_DEPTH = 2'd3;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [31:0] word;
        logic        start_req;
        logic        block_last;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] props_offset;
        logic [19:0] end_offset;
    } result_t;

    // one word after decoding by the front end
    typedef struct packed {
        logic        start;
        logic        last;
        logic [2:0]  tok;
        logic        zero_byte;
        logic        len_zero;
        logic [29:0] skip;
    } cls_t;

endpackage

`default_nettype wire

### sv/fdt_node_extent_scanner.sv
// ----------------------------------------------------------------------------
// fdt_node_extent_scanner
// Walks a device-tree structure block and reports one node's extent.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : one structure word per word transfer (item_valid/item_stall),
//                    start_req on the BEGIN_NODE word of the node, block_last on
//                    the final word of the block.
//   result channel : one word per scan (result_valid/result_stall): status and,
//                    on success, the properties offset and the offset past the
//                    closing END_NODE, in words from the node start.
//   Throughput is one word per cycle while no held result is stalled: each word takes one pass of the walker.
//   The result register loads when the word that ends the scan leaves the queue;
//   scans that end on idle words give nothing.
//   Words sit in a four-entry decode queue; when the receiver stalls a held
//   result, the walker stops draining the queue and item_stall rises once
//   the queue is full.
//   Reset clears the queue, the walker (idle, waiting for start) and result_valid;
//   item_stall is high and no word is taken while rst_n is low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "fdt_node_extent_scanner_macros.svh"

module fdt_node_extent_scanner
    import fdt_nes_pkg::*;
#(
    parameter int MAX_DEPTH   = 255,
    parameter int OFFSET_BITS = 20
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    cls_t cls;
    cls_t q_data;
    logic q_full;
    logic q_valid;
    logic pop;
    logic push;

    assign item_stall = q_full || !rst_n;
    assign push       = item_valid && !item_stall;

    fdt_nes_classify u_classify
    (
        .item (item),
        .cls  (cls)
    );

    fdt_nes_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (cls),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    fdt_nes_walker #(
        .MAX_DEPTH   (MAX_DEPTH),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_walker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `FDT_ASSERT_NOW(a_pop_room, pop, !result_valid || !result_stall, "walker popped with result blocked")
    `FDT_ASSERT_NEXT(a_push_lands, push, q_valid, "accepted word missing from queue")
    `FDT_ASSERT_NOW(a_err_zero, result_valid && (result.status != ST_OK),
        (result.props_offset == 20'd0) && (result.end_offset == 20'd0),
        "error result with non-zero offsets")

endmodule

`default_nettype wire

### sv/fdt_nes_classify.sv
// ----------------------------------------------------------------------------
// fdt_nes_classify
// Front-end decode of one structure word: token, zero byte, property skip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdt_nes_classify
    import fdt_nes_pkg::*;
(
    input  item_t item,
    output cls_t  cls
);

    always_comb
    begin
        cls.start      = item.start_req;
        cls.last       = item.block_last;
        cls.zero_byte  = (item.word[31:24] == 8'd0) || (item.word[23:16] == 8'd0) ||
                         (item.word[15:8] == 8'd0) || (item.word[7:0] == 8'd0);
        cls.len_zero   = (item.word == 32'd0);
        // ceil(len/4) - 1: a part-filled last word already counts in len/4
        cls.skip       = item.word[31:2] - 30'(item.word[1:0] == 2'b00);
        case (item.word)
            TOKEN_BEGIN_NODE: cls.tok = TK_BEGIN;
            TOKEN_END_NODE:   cls.tok = TK_END_NODE;
            TOKEN_PROP:       cls.tok = TK_PROP;
            TOKEN_NOP:        cls.tok = TK_NOP;
            default:          cls.tok = TK_BAD;
        endcase
    end

endmodule

`default_nettype wire

### sv/fdt_nes_queue.sv
// ----------------------------------------------------------------------------
// fdt_nes_queue
// Short register queue between the decode front end and the walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdt_nes_queue
    import fdt_nes_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    output logic full,
    input  logic pop,
    output logic q_valid,
    output cls_t q_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cls_t          entry_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### sv/fdt_nes_walker.sv
// ----------------------------------------------------------------------------
// fdt_nes_walker
// Back end: token walk with nesting depth, offsets and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fdt_nes_walker
    import fdt_nes_pkg::*;
#(
    parameter int MAX_DEPTH   = 255,
    parameter int OFFSET_BITS = 20
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  cls_t    q_data,
    output logic    pop,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int DW = $clog2(MAX_DEPTH + 1);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_NAME       = 3'd1;
    localparam logic [2:0] PH_TOKEN      = 3'd2;
    localparam logic [2:0] PH_PLEN       = 3'd3;
    localparam logic [2:0] PH_NOFF_EMPTY = 3'd4;
    localparam logic [2:0] PH_NOFF_DATA  = 3'd5;
    localparam logic [2:0] PH_DATA       = 3'd6;

    logic [2:0]             phase_reg, phase_next;
    logic [DW-1:0]          depth_reg, depth_next;
    logic [29:0]            skip_reg, skip_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] props_reg, props_next;
    logic                   pend_reg, pend_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                out_reg, out_next;

    logic                   fire;
    logic                   done;
    result_t                res;

    // a word leaves the queue only when the result register can take a result
    assign pop          = q_valid && (!out_valid_reg || !result_stall);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        phase_next = phase_reg;
        depth_next = depth_reg;
        skip_next  = skip_reg;
        pos_next   = pos_reg;
        props_next = props_reg;
        pend_next  = pend_reg;
        done       = 1'b0;
        res        = '0;

        if (pop)
        begin
            if (q_data.start)
            begin
                pos_next   = '0;
                props_next = '0;
                skip_next  = '0;
                if (q_data.tok != TK_BEGIN)
                begin
                    depth_next = '0;
                    pend_next  = 1'b0;
                    done       = 1'b1;
                    res.status = ST_BAD;
                end
                else
                begin
                    depth_next = DW'(1);
                    pend_next  = 1'b1;
                    phase_next = PH_NAME;
                    if (q_data.last)
                    begin
                        done       = 1'b1;
                        res.status = ST_TRUNC;
                    end
                end
            end
            else if (phase_reg != PH_IDLE)
            begin
                pos_next = OFFSET_BITS'(pos_reg + 1'b1);
                case (phase_reg)
                    PH_NAME:
                    begin
                        if (q_data.zero_byte)
                        begin
                            if (pend_reg)
                            begin
                                props_next = OFFSET_BITS'(pos_next + 1'b1);
                                pend_next  = 1'b0;
                            end
                            phase_next = PH_TOKEN;
                        end
                    end
                    PH_TOKEN:
                    begin
                        case (q_data.tok)
                            TK_BEGIN:
                            begin
                                if (depth_reg >= DW'(MAX_DEPTH))
                                begin
                                    done       = 1'b1;
                                    res.status = ST_DEPTH;
                                end
                                else
                                begin
                                    depth_next = depth_reg + 1'b1;
                                    phase_next = PH_NAME;
                                end
                            end
                            TK_END_NODE:
                            begin
                                if (depth_reg <= DW'(1))
                                begin
                                    depth_next       = '0;
                                    done             = 1'b1;
                                    res.status       = ST_OK;
                                    res.props_offset = 20'(props_reg);
                                    res.end_offset   = 20'(OFFSET_BITS'(pos_next + 1'b1));
                                end
                                else
                                begin
                                    depth_next = depth_reg - 1'b1;
                                end
                            end
                            TK_PROP:
                            begin
                                phase_next = PH_PLEN;
                            end
                            TK_NOP:
                            begin
                            end
                            default:
                            begin
                                done       = 1'b1;
                                res.status = ST_BAD;
                            end
                        endcase
                    end
                    PH_PLEN:
                    begin
                        if (q_data.len_zero)
                        begin
                            phase_next = PH_NOFF_EMPTY;
                        end
                        else
                        begin
                            skip_next  = q_data.skip;
                            phase_next = PH_NOFF_DATA;
                        end
                    end
                    PH_NOFF_EMPTY:
                    begin
                        phase_next = PH_TOKEN;
                    end
                    PH_NOFF_DATA:
                    begin
                        phase_next = PH_DATA;
                    end
                    default:
                    begin
                        if (skip_reg == '0)
                        begin
                            phase_next = PH_TOKEN;
                        end
                        else
                        begin
                            skip_next = skip_reg - 1'b1;
                        end
                    end
                endcase
                if (!done && q_data.last)
                begin
                    done       = 1'b1;
                    res.status = ST_TRUNC;
                end
            end
            if (done)
            begin
                phase_next = PH_IDLE;
            end
        end
    end

    assign fire = pop && done;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            depth_reg     <= '0;
            skip_reg      <= '0;
            pos_reg       <= '0;
            props_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            depth_reg     <= depth_next;
            skip_reg      <= skip_next;
            pos_reg       <= pos_next;
            props_reg     <= props_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

### bench/tb_fdt_node_extent_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fdt_node_extent_scanner
// Self-checking bench for the device-tree node extent scanner.
// Structure-block words are fed from a queue with random gaps. Each accepted
// word is walked through a local token walker that predicts the scan result.
// Results taken off the result channel are checked field by field against
// the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fdt_node_extent_scanner;
    import fdt_nes_pkg::*;

    localparam int          DEPTH_LIMIT = 255;
    localparam logic [31:0] TOKEN_END   = 32'd9;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          TOTAL_WORDS = 1250;
    localparam int          CALM_WORDS  = 150;

    typedef enum logic [2:0] {
        W_IDLE, W_NAME, W_TOKEN, W_PLEN, W_NOFF_EMPTY, W_NOFF_DATA, W_DATA
    } walk_t;

    typedef struct {
        item_t w;
        bit    drain;
    } feed_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    feed_t   feed[$];
    result_t expected_results[$];
    item_t   scan[$];
    int      tok_slots[$];

    // token walker state
    walk_t        walk = W_IDLE;
    int unsigned  depth = 0;
    logic [29:0]  skip_left = '0;
    logic [19:0]  pos = '0;
    logic [19:0]  props_at = '0;
    bit           name_open = 1'b0;

    bit           word_taken = 1'b0;
    int           send_gap = 0;
    int           stall_left = 0;
    int           mismatches = 0;
    int unsigned  cycles = 0;

    fdt_node_extent_scanner uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch: %s: got %0h, expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // walks one accepted word and queues the result it ends with, if any
    task automatic walk_word(item_t it);
        result_t     r;
        bit          done;
        logic [31:0] nw;
        logic [31:0] w;
        r = '0;
        done = 1'b0;
        w = it.word;
        if (it.start_req)
        begin
            pos = '0;
            props_at = '0;
            skip_left = '0;
            if (w != TOKEN_BEGIN_NODE)
            begin
                depth = 0;
                name_open = 1'b0;
                r.status = ST_BAD;
                done = 1'b1;
            end
            else
            begin
                depth = 1;
                name_open = 1'b1;
                walk = W_NAME;
                if (it.block_last)
                begin
                    r.status = ST_TRUNC;
                    done = 1'b1;
                end
            end
        end
        else if (walk != W_IDLE)
        begin
            pos = pos + 20'd1;
            case (walk)
                W_NAME:
                begin
                    if (w[31:24] == 8'd0 || w[23:16] == 8'd0 || w[15:8] == 8'd0 ||
                        w[7:0] == 8'd0)
                    begin
                        if (name_open)
                            props_at = pos + 20'd1;
                        name_open = 1'b0;
                        walk = W_TOKEN;
                    end
                end
                W_TOKEN:
                begin
                    if (w == TOKEN_BEGIN_NODE)
                    begin
                        if (depth >= DEPTH_LIMIT)
                        begin
                            r.status = ST_DEPTH;
                            done = 1'b1;
                        end
                        else
                        begin
                            depth++;
                            walk = W_NAME;
                        end
                    end
                    else if (w == TOKEN_END_NODE)
                    begin
                        if (depth <= 1)
                        begin
                            depth = 0;
                            r.status = ST_OK;
                            r.props_offset = props_at;
                            r.end_offset = pos + 20'd1;
                            done = 1'b1;
                        end
                        else
                            depth--;
                    end
                    else if (w == TOKEN_PROP)
                        walk = W_PLEN;
                    else if (w != TOKEN_NOP)
                    begin
                        r.status = ST_BAD;
                        done = 1'b1;
                    end
                end
                W_PLEN:
                begin
                    nw = {2'b00, w[31:2]} + {31'd0, w[1:0] != 2'b00};
                    if (nw == 32'd0)
                        walk = W_NOFF_EMPTY;
                    else
                    begin
                        skip_left = nw[29:0] - 30'd1;
                        walk = W_NOFF_DATA;
                    end
                end
                W_NOFF_EMPTY: walk = W_TOKEN;
                W_NOFF_DATA:  walk = W_DATA;
                default:
                begin
                    if (skip_left == '0)
                        walk = W_TOKEN;
                    else
                        skip_left = skip_left - 30'd1;
                end
            endcase
            if (!done && it.block_last)
            begin
                r = '0;
                r.status = ST_TRUNC;
                done = 1'b1;
            end
        end
        if (done)
        begin
            walk = W_IDLE;
            expected_results.push_back(r);
        end
    endtask

    function automatic item_t mk(logic [31:0] w);
        item_t it;
        it = '0;
        it.word = w;
        return it;
    endfunction

    task automatic push_word(logic [31:0] w, bit s = 1'b0, bit l = 1'b0, bit d = 1'b0);
        feed_t f;
        f.w.word = w;
        f.w.start_req = s;
        f.w.block_last = l;
        f.drain = d;
        feed.push_back(f);
    endtask

    task automatic add_name();
        logic [31:0] t;
        int          k;
        repeat ($urandom_range(0, 3))
            scan.push_back(mk({8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                               8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))}));
        t = $urandom;
        k = $urandom_range(0, 3);
        t[k*8 +: 8] = 8'h00;
        scan.push_back(mk(t));
    endtask

    task automatic add_prop();
        logic [31:0] len;
        tok_slots.push_back(scan.size());
        scan.push_back(mk(TOKEN_PROP));
        len = ($urandom_range(0, 39) == 0) ? $urandom : $urandom_range(0, 24);
        scan.push_back(mk(len));
        scan.push_back(mk($urandom));
        if (len <= 32'd64)
            repeat ((len + 3) / 4) scan.push_back(mk($urandom));
    endtask

    task automatic add_node(int lvl);
        tok_slots.push_back(scan.size());
        scan.push_back(mk(TOKEN_BEGIN_NODE));
        add_name();
        repeat ($urandom_range(0, 4))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    tok_slots.push_back(scan.size());
                    scan.push_back(mk(TOKEN_NOP));
                end
                1:
                begin
                    if (lvl < 3)
                        add_node(lvl + 1);
                    else
                        add_prop();
                end
                default: add_prop();
            endcase
        end
        tok_slots.push_back(scan.size());
        scan.push_back(mk(TOKEN_END_NODE));
    endtask

    // one node scan with random content, sometimes broken on purpose
    task automatic add_random_scan();
        int k;
        scan.delete();
        tok_slots.delete();
        add_node(0);
        scan[0].start_req = 1'b1;
        case ($urandom_range(0, 11))
            0:
            begin
                k = $urandom_range(0, scan.size() - 1);
                scan[k].block_last = 1'b1;
                while (scan.size() > k + 1) void'(scan.pop_back());
            end
            1:
            begin
                // abandoned part way, next start_req restarts
                k = $urandom_range(1, scan.size() - 1);
                while (scan.size() > k) void'(scan.pop_back());
            end
            2:
            begin
                k = tok_slots[$urandom_range(0, tok_slots.size() - 1)];
                scan[k].word = ($urandom_range(0, 1) == 1) ? TOKEN_END : $urandom;
                while (scan.size() > k + 1) void'(scan.pop_back());
            end
            3: scan[$urandom_range(0, scan.size() - 1)].word = $urandom;
            4: scan[scan.size() - 1].block_last = 1'b1;
            default: ;
        endcase
        foreach (scan[i])
            push_word(scan[i].word, scan[i].start_req, scan[i].block_last,
                      i == 0 && $urandom_range(0, 29) == 0);
        // stray words between scans
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                push_word($urandom, 1'b0, $urandom_range(0, 3) == 0);
    endtask

    // nests until the depth limit trips
    task automatic add_deep_scan();
        push_word(TOKEN_BEGIN_NODE, 1'b1, 1'b0, 1'b1);
        push_word(32'h0);
        repeat (DEPTH_LIMIT)
        begin
            push_word(TOKEN_BEGIN_NODE);
            push_word(32'h6e000000);
        end
    endtask

    // word driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (word_taken || !item_valid)
            begin
                word_taken = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (feed.size() == 0)
                    item_valid <= 1'b0;
                else if (feed[0].drain && expected_results.size() != 0)
                    item_valid <= 1'b0;
                else
                begin
                    item <= feed[0].w;
                    item_valid <= 1'b1;
                    void'(feed.pop_front());
                    if (feed.size() >= CALM_WORDS && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 18);
                end
            end
        end
    end

    // result-side stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (feed.size() >= CALM_WORDS && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 17);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                walk_word(item);
                word_taken = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result word with none pending", 64'(result), 64'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch("status", 64'(result.status), 64'(want.status));
                    if (result.props_offset !== want.props_offset)
                        report_mismatch("props_offset", 64'(result.props_offset),
                                        64'(want.props_offset));
                    if (result.end_offset !== want.end_offset)
                        report_mismatch("end_offset", 64'(result.end_offset),
                                        64'(want.end_offset));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        // directed words
        push_word(32'hFFFFFFFF, 1'b0, 1'b1);                 // ignored while idle
        push_word(TOKEN_END, 1'b1, 1'b1);                    // bad first word on last word
        push_word(TOKEN_BEGIN_NODE, 1'b1, 1'b1);             // block ends on start
        push_word(TOKEN_BEGIN_NODE, 1'b1);                   // smallest node
        push_word(32'h00000000);
        push_word(TOKEN_END_NODE);
        push_word(TOKEN_BEGIN_NODE, 1'b1);                   // two-word name, props, nop
        push_word(32'h61626364);
        push_word(32'h65000000);
        push_word(TOKEN_PROP);
        push_word(32'd5);
        push_word(32'h0000001c);
        push_word(32'hFFFFFFFF);
        push_word(32'h80000000);
        push_word(TOKEN_NOP);
        push_word(TOKEN_END_NODE, 1'b0, 1'b1);
        push_word(TOKEN_BEGIN_NODE, 1'b1);                   // END token
        push_word(32'h00616200);
        push_word(TOKEN_END);
        push_word(TOKEN_BEGIN_NODE, 1'b1);                   // huge property length
        push_word(32'h7a7a7a00);
        push_word(TOKEN_PROP);
        push_word(32'hFFFFFFFF);
        push_word(32'h00000004);
        push_word(32'h12345678, 1'b0, 1'b1);

        while (feed.size() < TOTAL_WORDS / 3)
            add_random_scan();
        add_deep_scan();
        while (feed.size() < TOTAL_WORDS)
            add_random_scan();

        repeat (7) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        while (feed.size() != 0 || item_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results left pending", 64'(expected_results.size()), 64'd0);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
